@@ rtl/lzss_pkg.sv @@
// Shared types and constants of the LZSS window decoder.
`default_nettype none

package lzss_pkg;

    localparam int WINDOW_SIZE = 4096;

    localparam logic [11:0] START_POS  = 12'hFEE;
    localparam logic [8:0]  FLAG_INIT  = 9'h002;
    localparam logic [8:0]  FLAG_EMPTY = 9'h001;
    localparam logic [4:0]  LEN_BIAS   = 5'd3;

    typedef enum logic [1:0] {
        PH_ITEM = 2'd0,
        PH_LOW  = 2'd1,
        PH_HIGH = 2'd2
    } t_phase;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_COPY = 1'b1
    } t_state;

    typedef struct packed {
        logic [7:0]  in_byte;
        logic        chunk_begin;
        logic [15:0] out_limit;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       chunk_done;
    } t_out;

endpackage

`default_nettype wire

@@ rtl/lzss_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module lzss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/lzss_window_decoder.sv @@
// Top level of the LZSS decoder with a 4 KiB history window.
// Compressed bytes enter one per transaction; a flag byte or an offset low byte gives no
// result, a literal gives one byte, and a back reference copies up to 18 bytes, read one
// after another from the single read port of the window memory while the input stalls;
// the read data is forwarded when a copy reads the entry that it is writing at the same
// time. A chunk start clears the window at once: an entry counts as written only when it
// lies within the bytes emitted so far in the chunk, so no clearing pass is needed and
// unwritten entries read as zero.
`default_nettype none

module lzss_window_decoder #(
    parameter int WINDOW_SIZE = lzss_pkg::WINDOW_SIZE
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire lzss_pkg::t_in i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output lzss_pkg::t_out     o_out
);

    localparam int AW = $clog2(WINDOW_SIZE);

    lzss_pkg::t_state r_state, n_state;
    lzss_pkg::t_phase r_phase, n_phase;
    logic [8:0]       r_flag, n_flag;
    logic [7:0]       r_low, n_low;
    logic [15:0]      r_count, n_count;
    logic [15:0]      r_limit, n_limit;
    logic [AW-1:0]    r_wp, n_wp;
    logic [AW-1:0]    r_src, n_src;
    logic [4:0]       r_remain, n_remain;
    logic             r_fwd, n_fwd;
    logic [7:0]       r_fwd_data, n_fwd_data;
    logic             r_out_valid, n_out_valid;
    lzss_pkg::t_out   r_out, n_out;

    logic          in_take;
    logic          advance;
    logic          copy_start;
    logic          push;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_q;

    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != lzss_pkg::ST_IDLE) || !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    lzss_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_SIZE)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_q)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            lzss_pkg::ST_IDLE: begin
                if (in_take && copy_start) begin
                    n_state = lzss_pkg::ST_COPY;
                end
            end
            lzss_pkg::ST_COPY: begin
                if (advance && (r_remain == 5'd1)) begin
                    n_state = lzss_pkg::ST_IDLE;
                end
            end
            default: n_state = lzss_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        logic [7:0]       b;
        lzss_pkg::t_phase e_phase;
        logic [8:0]       e_flag;
        logic [7:0]       e_low;
        logic [15:0]      e_count;
        logic [15:0]      e_limit;
        logic [AW-1:0]    e_wp;
        logic [8:0]       sh;
        logic             do_low;
        logic             do_high;
        logic [4:0]       cnt;
        logic [15:0]      room;
        logic [AW-1:0]    rel_pos;
        logic             hit;
        logic [7:0]       rd;

        n_phase     = r_phase;
        n_flag      = r_flag;
        n_low       = r_low;
        n_count     = r_count;
        n_limit     = r_limit;
        n_wp        = r_wp;
        n_src       = r_src;
        n_remain    = r_remain;
        n_fwd       = r_fwd;
        n_fwd_data  = r_fwd_data;
        n_out       = r_out;
        push        = 1'b0;
        copy_start  = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_wp;
        mem_wdata   = 8'h00;
        mem_re      = 1'b0;
        mem_raddr   = r_src;

        b       = i_in.in_byte;
        e_phase = i_in.chunk_begin ? lzss_pkg::PH_ITEM : r_phase;
        e_flag  = i_in.chunk_begin ? lzss_pkg::FLAG_INIT : r_flag;
        e_low   = i_in.chunk_begin ? 8'h00 : r_low;
        e_count = i_in.chunk_begin ? 16'h0000 : r_count;
        e_limit = i_in.chunk_begin ? i_in.out_limit : r_limit;
        e_wp    = i_in.chunk_begin ? AW'(lzss_pkg::START_POS) : r_wp;
        sh      = e_flag >> 1;
        do_low  = 1'b0;
        do_high = 1'b0;
        cnt     = lzss_pkg::LEN_BIAS + 5'(b[3:0]);
        room    = (e_limit > e_count) ? (e_limit - e_count) : 16'h0000;

        rel_pos = r_src - AW'(lzss_pkg::START_POS);
        hit     = (r_count >= 16'(WINDOW_SIZE)) || (16'(rel_pos) < r_count);
        rd      = r_fwd ? r_fwd_data : (hit ? mem_q : 8'h00);

        if ((r_state == lzss_pkg::ST_IDLE) && in_take) begin
            n_phase = e_phase;
            n_flag  = e_flag;
            n_low   = e_low;
            n_count = e_count;
            n_limit = e_limit;
            n_wp    = e_wp;
            case (e_phase)
                lzss_pkg::PH_LOW:  do_low = 1'b1;
                lzss_pkg::PH_HIGH: do_high = 1'b1;
                default: begin
                    if (e_count < e_limit) begin
                        if (sh == lzss_pkg::FLAG_EMPTY) begin
                            n_flag  = {1'b1, b};
                            n_phase = lzss_pkg::PH_LOW;
                        end else begin
                            n_flag = sh;
                            do_low = 1'b1;
                        end
                    end
                end
            endcase

            if (do_low) begin
                if (n_flag[0]) begin
                    mem_we    = 1'b1;
                    mem_waddr = e_wp;
                    mem_wdata = b;
                    push      = 1'b1;
                    n_out     = '{out_byte: b, run_last: 1'b1,
                                  chunk_done: ((e_count + 16'd1) == e_limit)};
                    n_wp      = e_wp + AW'(1);
                    n_count   = e_count + 16'd1;
                    n_phase   = lzss_pkg::PH_ITEM;
                end else begin
                    n_low   = b;
                    n_phase = lzss_pkg::PH_HIGH;
                end
            end

            if (do_high) begin
                if (16'(cnt) > room) begin
                    cnt = room[4:0];
                end
                n_phase = lzss_pkg::PH_ITEM;
                if (cnt != 5'd0) begin
                    copy_start = 1'b1;
                    mem_re     = 1'b1;
                    mem_raddr  = AW'({b[7:4], e_low});
                    n_src      = AW'({b[7:4], e_low});
                    n_remain   = cnt;
                    n_fwd      = 1'b0;
                end
            end
        end else if ((r_state == lzss_pkg::ST_COPY) && advance) begin
            mem_we    = 1'b1;
            mem_waddr = r_wp;
            mem_wdata = rd;
            push      = 1'b1;
            n_out     = '{out_byte: rd, run_last: (r_remain == 5'd1),
                          chunk_done: ((r_count + 16'd1) == r_limit)};
            n_wp      = r_wp + AW'(1);
            n_count   = r_count + 16'd1;
            n_remain  = r_remain - 5'd1;
            if (r_remain != 5'd1) begin
                mem_re     = 1'b1;
                mem_raddr  = r_src + AW'(1);
                n_src      = r_src + AW'(1);
                n_fwd      = ((r_src + AW'(1)) == r_wp);
                n_fwd_data = rd;
            end
        end

        n_out_valid = push || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lzss_pkg::ST_IDLE;
            r_phase     <= lzss_pkg::PH_ITEM;
            r_flag      <= lzss_pkg::FLAG_INIT;
            r_low       <= 8'h00;
            r_count     <= 16'h0000;
            r_limit     <= 16'h0000;
            r_wp        <= AW'(lzss_pkg::START_POS);
            r_remain    <= 5'd0;
            r_fwd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_flag      <= n_flag;
            r_low       <= n_low;
            r_count     <= n_count;
            r_limit     <= n_limit;
            r_wp        <= n_wp;
            r_remain    <= n_remain;
            r_fwd       <= n_fwd;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src      <= n_src;
        r_fwd_data <= n_fwd_data;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

@@ rtl/lzss_checker.sv @@
// Port-level checker for the LZSS window decoder, bound to its top level.
`default_nettype none

module lzss_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           o_in_stall,
    input wire logic           o_out_valid,
    input wire logic           i_out_stall,
    input wire lzss_pkg::t_out o_out
);

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed or dropped");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    // Reaching the chunk limit always ends the run of the current input byte.
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.chunk_done |-> o_out.run_last)
        else $error("chunk done on a result that is not the last of its run");

    // While a copy run is still going, no new input transaction is taken.
    a_run_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.run_last |-> o_in_stall)
        else $error("input taken in the middle of a copy run");

endmodule

bind lzss_window_decoder lzss_checker u_lzss_checker (.*);

`default_nettype wire

@@ tb/lzss_window_decoder_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the LZSS window decoder, with a byte-exact decode predictor.
module lzss_window_decoder_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int TAIL_CYCLES    = 40;
    localparam int RANDOM_TARGET  = 330;
    localparam int ITEM_TARGET    = 430;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    lzss_pkg::t_in  in_data = '0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    lzss_pkg::t_out out_data;

    bit sender_idle   = 1'b0;
    bit receiver_idle = 1'b0;
    bit hold_request  = 1'b0;
    int error_count    = 0;
    int items_sent     = 0;
    int items_decoded  = 0;
    int bytes_checked  = 0;
    int chunks_started = 0;
    int idle_cycles    = 0;

    logic [7:0]       win_hist [lzss_pkg::WINDOW_SIZE];
    logic [11:0]      win_pos;
    logic [8:0]       flag_sr;
    lzss_pkg::t_phase item_phase;
    logic [7:0]       offset_low;
    logic [15:0]      out_total;
    logic [15:0]      out_limit_reg;
    lzss_pkg::t_out   expected_bytes [$];

    always #6 clk = ~clk;

    lzss_window_decoder dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_data)
    );

    function automatic void clear_window();
        foreach (win_hist[i]) win_hist[i] = '0;
        win_pos    = lzss_pkg::START_POS;
        flag_sr    = lzss_pkg::FLAG_INIT;
        item_phase = lzss_pkg::PH_ITEM;
        offset_low = '0;
        out_total  = '0;
    endfunction

    function automatic void emit_byte(input logic [7:0] value, input bit last);
        lzss_pkg::t_out res;
        win_hist[win_pos] = value;
        win_pos++;
        out_total++;
        res.out_byte   = value;
        res.run_last   = last;
        res.chunk_done = (out_total == out_limit_reg);
        expected_bytes.insert(expected_bytes.size(), res);
    endfunction

    // Returns 0 when the byte is ignored because the chunk's output limit is reached.
    function automatic bit decode_byte(input lzss_pkg::t_in item);
        logic [11:0] src;
        int unsigned run_len;
        int unsigned room;
        if (item.chunk_begin) begin
            clear_window();
            out_limit_reg = item.out_limit;
        end
        if (item_phase != lzss_pkg::PH_LOW && item_phase != lzss_pkg::PH_HIGH) begin
            if (out_total >= out_limit_reg) return 1'b0;
            flag_sr = flag_sr >> 1;
            if (flag_sr == lzss_pkg::FLAG_EMPTY) begin
                flag_sr    = {1'b1, item.in_byte};
                item_phase = lzss_pkg::PH_LOW;
                return 1'b1;
            end
            item_phase = lzss_pkg::PH_LOW;
        end
        if (item_phase == lzss_pkg::PH_LOW) begin
            if (flag_sr[0]) begin
                emit_byte(item.in_byte, 1'b1);
                item_phase = lzss_pkg::PH_ITEM;
            end else begin
                offset_low = item.in_byte;
                item_phase = lzss_pkg::PH_HIGH;
            end
        end else begin
            src     = {item.in_byte[7:4], offset_low};
            run_len = 32'(lzss_pkg::LEN_BIAS) + 32'(item.in_byte[3:0]);
            room    = (out_limit_reg > out_total) ? 32'(out_limit_reg - out_total) : 0;
            if (run_len > room) run_len = room;
            for (int unsigned i = 0; i < run_len; i++) begin
                emit_byte(win_hist[src], i == run_len - 1);
                src++;
            end
            item_phase = lzss_pkg::PH_ITEM;
        end
        return 1'b1;
    endfunction

    task automatic send_byte(input logic [7:0] value, input logic start, input logic [15:0] lim);
        lzss_pkg::t_in item;
        item.in_byte     = value;
        item.chunk_begin = start;
        item.out_limit   = lim;
        if (sender_idle && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
        if (start) chunks_started++;
        if (decode_byte(item)) items_decoded++;
    endtask

    task automatic send_data(input logic [7:0] value);
        send_byte(value, 1'b0, 16'($urandom));
    endtask

    // Well-formed flag groups of random content, the last cut at a reference if cut_short;
    // references mostly point just behind the write position to overlap recent output.
    task automatic send_random_chunk(input logic [15:0] lim, input int groups,
                                     input int ref_pct, input bit cut_short);
        logic [7:0]  flags;
        logic [11:0] off;
        for (int g = 0; g < groups; g++) begin
            for (int k = 0; k < 8; k++) flags[k] = ($urandom_range(0, 99) >= ref_pct);
            send_byte(flags, g == 0, g == 0 ? lim : 16'($urandom));
            for (int k = 0; k < 8; k++) begin
                if (flags[k]) begin
                    send_data(8'($urandom));
                end else begin
                    off = win_pos - 12'($urandom_range(1, 24));
                    if ($urandom_range(0, 3) == 0) off = 12'($urandom);
                    send_data(off[7:0]);
                    if (cut_short && g == groups - 1) return;
                    send_data({off[11:8], 4'($urandom)});
                end
            end
        end
    endtask

    task automatic test_before_first_chunk();
        send_data(8'hFF);
        send_data(8'h00);
        send_byte(8'hA5, 1'b1, 16'h0000);
        send_data(8'h3C);
    endtask

    task automatic test_literals_and_references();
        send_byte(8'h0B, 1'b1, 16'hFFFF);
        send_data(8'h00);
        send_data(8'hFF);
        send_data(8'h00);
        send_data(8'h00);
        send_data(8'h5A);
        send_data(8'hF3);
        send_data(8'hFF);
        send_data(8'hFE);
        send_data(8'hF2);
        send_data(8'h12);
    endtask

    task automatic test_clipping_and_done();
        send_byte(8'h01, 1'b1, 16'd5);
        send_data(8'h77);
        send_data(8'hEE);
        send_data(8'hFF);
        send_data(8'h99);
        send_data(8'h01);
        send_byte(8'hFF, 1'b1, 16'd1);
        send_data(8'h81);
        send_data(8'h42);
    endtask

    task automatic test_random_streams();
        int sel;
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        while (items_sent < RANDOM_TARGET) begin
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom), $urandom_range(0, 5) == 0, 16'($urandom));
            end else begin
                send_random_chunk(sel == 1 ? 16'($urandom) : 16'($urandom_range(1, 160)),
                                  $urandom_range(1, 4), $urandom_range(10, 90),
                                  $urandom_range(0, 7) == 0);
            end
        end
    endtask

    task automatic test_backpressure();
        sender_idle  = 1'b0;
        hold_request = 1'b1;
        send_random_chunk(16'hFFFF, 3, 100, 1'b0);
        sender_idle  = 1'b1;
    endtask

    task automatic test_steady_stream();
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        while (items_sent < ITEM_TARGET)
            send_random_chunk(16'($urandom_range(40, 400)), $urandom_range(1, 3), 50, 1'b0);
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t ns: %s expected %02h, actual %02h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk) begin
        lzss_pkg::t_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_bytes.size() == 0) begin
                error_count++;
                $display("%0t ns: result with nothing expected, actual %p", $time, out_data);
            end else begin
                want = expected_bytes.pop_front();
                bytes_checked++;
                check_field("out_byte", want.out_byte, out_data.out_byte);
                check_field("run_last", want.run_last, out_data.run_last);
                check_field("chunk_done", want.chunk_done, out_data.chunk_done);
            end
        end
    end

    initial begin
        forever begin
            @(posedge clk);
            if (hold_request) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_request = 1'b0;
            end else if (receiver_idle && $urandom_range(0, 4) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no transaction for %0d cycles", $time, idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        clear_window();
        out_limit_reg = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_before_first_chunk();
        test_literals_and_references();
        test_clipping_and_done();
        test_random_streams();
        test_backpressure();
        test_steady_stream();
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d compressed bytes (%0d decoded) in %0d chunk starts;",
                 items_sent, items_decoded, chunks_started);
        $display("%0d output bytes checked over literals, overlapping and wrapping %s",
                 bytes_checked, "references, clipped copies and a long output hold-off.");
        if (error_count == 0 && expected_bytes.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ lzss_window_decoder.f @@
rtl/lzss_pkg.sv
rtl/lzss_ram.sv
rtl/lzss_window_decoder.sv
rtl/lzss_checker.sv
tb/lzss_window_decoder_tb.sv
